>>> hw/rtl/seven_segment_display_frame_builder_macros.svh
// Assertion macros shared by the frame builder modules.
`ifndef SEVEN_SEGMENT_DISPLAY_FRAME_BUILDER_MACROS_SVH
`define SEVEN_SEGMENT_DISPLAY_FRAME_BUILDER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SSDFB_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("ssdfb assertion failed");
// next-cycle implication
`define SSDFB_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("ssdfb assertion failed");
`else
`define SSDFB_ASSERT_IMPLY(label, clk, rst, a, b)
`define SSDFB_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

>>> hw/rtl/ssdfb_pkg.sv
package ssdfb_pkg;

  localparam int DIGIT_SLOTS = 4;
  localparam int QUEUE_DEPTH = 2;  // power of two, pointers wrap freely

  typedef enum logic [1:0] {
    OP_RAW   = 2'd0,
    OP_INT   = 2'd1,
    OP_TIME  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  localparam logic signed [14:0] NUM_MAX  = 15'sd9999;
  localparam logic signed [14:0] NUM_MIN  = -15'sd999;
  localparam logic [7:0]         PAIR_MAX = 8'd99;

  localparam logic [7:0] CMD_DATA   = 8'h40;
  localparam logic [7:0] CMD_ADDR   = 8'hC0;
  localparam logic [7:0] CMD_CTRL   = 8'h80 | 8'h08;
  localparam logic [7:0] SEG_MINUS  = 8'h40;
  localparam logic [7:0] SEG_COLON  = 8'h80;
  localparam logic [2:0] BRIGHT_RST = 3'h7;

  // one classified command, ready for byte emission
  typedef struct packed {
    logic [3:0][7:0] segs;
    logic [2:0]      cnt;
    logic [1:0]      pos;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  digit;
    logic [13:0] rem;
  } digit_rem_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0:    g = 8'h3F;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5B;
      4'd3:    g = 8'h4F;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6D;
      4'd6:    g = 8'h7D;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h6F;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // one decimal digit: parallel compares against multiples of the weight
  function automatic digit_rem_t split_digit(input logic [13:0] x,
                                             input logic [13:0] weight);
    digit_rem_t r;
    r.digit = 4'd0;
    r.rem   = x;
    for (int k = 1; k <= 9; k++) begin
      if (x >= 14'(k) * weight) begin
        r.digit = 4'(k);
        r.rem   = x - 14'(k) * weight;
      end
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/ssdfb_front.sv
module ssdfb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [71:0]       in_data,
  output logic              push,
  output ssdfb_pkg::cmd_t   push_data,
  input  logic              q_full
);

  typedef struct packed {
    logic            reject;
    logic [1:0]      op;
    logic            neg;
    logic [13:0]     mag;
    logic [6:0]      left;
    logic [6:0]      right;
    logic [3:0][7:0] raw;
    logic [2:0]      cnt;
    logic [1:0]      pos;
  } stage_t;

  logic              s1_valid, s2_valid, s3_valid;
  stage_t            s1, s2, s3;
  stage_t            s0;
  stage_t            s1_fwd, s2_fwd;
  logic [3:0]        s2_d0;
  logic [3:0]        s3_d0, s3_d1;
  logic              adv;

  logic signed [14:0] num;
  logic signed [14:0] num_neg;
  logic [7:0]         left_in, right_in;
  logic [2:0]         dcount;
  ssdfb_pkg::digit_rem_t thou, hund, tens, lt, rt;
  logic               b0, b1, b2;
  ssdfb_pkg::cmd_t    cmd;

  // whole pipeline moves together; rejected items simply fall out the end
  assign adv      = !s3_valid || s3.reject || !q_full;
  assign in_ready = adv;
  assign push     = s3_valid && !s3.reject && !q_full;
  assign push_data = cmd;

  always_comb begin
    num      = $signed(in_data[14:0]);
    num_neg  = -num;
    left_in  = in_data[22:15];
    right_in = in_data[30:23];
    dcount   = in_data[65:63];
    s0.op    = in_op;
    s0.neg   = num < 0;
    s0.mag   = s0.neg ? num_neg[13:0] : num[13:0];
    s0.left  = left_in[6:0];
    s0.right = right_in[6:0];
    s0.raw   = {in_data[62:55], in_data[54:47], in_data[46:39], in_data[38:31]};
    s0.cnt   = (dcount > 3'(ssdfb_pkg::DIGIT_SLOTS)) ? 3'(ssdfb_pkg::DIGIT_SLOTS) : dcount;
    s0.pos   = in_data[67:66];
    s0.reject = ((in_op == ssdfb_pkg::OP_INT) &&
                 (num > ssdfb_pkg::NUM_MAX || num < ssdfb_pkg::NUM_MIN)) ||
                ((in_op == ssdfb_pkg::OP_TIME) &&
                 (left_in > ssdfb_pkg::PAIR_MAX || right_in > ssdfb_pkg::PAIR_MAX));
  end

  assign thou = ssdfb_pkg::split_digit(s1.mag, 14'd1000);
  assign hund = ssdfb_pkg::split_digit(s2.mag, 14'd100);

  // remainder travels on in place of the magnitude
  always_comb begin
    s1_fwd     = s1;
    s1_fwd.mag = {4'd0, thou.rem[9:0]};
    s2_fwd     = s2;
    s2_fwd.mag = {7'd0, hund.rem[6:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1    <= s0;
      s2    <= s1_fwd;
      s2_d0 <= thou.digit;
      s3    <= s2_fwd;
      s3_d0 <= s2_d0;
      s3_d1 <= hund.digit;
    end
  end

  assign tens = ssdfb_pkg::split_digit(s3.mag, 14'd10);
  assign lt   = ssdfb_pkg::split_digit(14'(s3.left), 14'd10);
  assign rt   = ssdfb_pkg::split_digit(14'(s3.right), 14'd10);

  always_comb begin
    b0 = s3_d0 == 4'd0;
    b1 = b0 && s3_d1 == 4'd0;
    b2 = b1 && tens.digit == 4'd0;
    cmd.cnt  = 3'(ssdfb_pkg::DIGIT_SLOTS);
    cmd.pos  = 2'd0;
    cmd.segs = '0;
    unique case (s3.op)
      ssdfb_pkg::OP_RAW: begin
        cmd.segs = s3.raw;
        cmd.cnt  = s3.cnt;
        cmd.pos  = s3.pos;
      end
      ssdfb_pkg::OP_INT: begin
        cmd.segs[0] = b0 ? 8'h00 : ssdfb_pkg::glyph(s3_d0);
        cmd.segs[1] = b1 ? 8'h00 : ssdfb_pkg::glyph(s3_d1);
        cmd.segs[2] = b2 ? 8'h00 : ssdfb_pkg::glyph(tens.digit);
        cmd.segs[3] = ssdfb_pkg::glyph(tens.rem[3:0]);
        // minus sits in the last blank place
        if (s3.neg) begin
          priority if (b2)      cmd.segs[2] = ssdfb_pkg::SEG_MINUS;
          else if (b1)          cmd.segs[1] = ssdfb_pkg::SEG_MINUS;
          else if (b0)          cmd.segs[0] = ssdfb_pkg::SEG_MINUS;
        end
      end
      ssdfb_pkg::OP_TIME: begin
        cmd.segs[0] = ssdfb_pkg::glyph(lt.digit);
        cmd.segs[1] = ssdfb_pkg::glyph(lt.rem[3:0]) | ssdfb_pkg::SEG_COLON;
        cmd.segs[2] = ssdfb_pkg::glyph(rt.digit);
        cmd.segs[3] = ssdfb_pkg::glyph(rt.rem[3:0]);
      end
      default: cmd.segs = '0;
    endcase
  end

endmodule

>>> hw/rtl/ssdfb_queue.sv
`include "seven_segment_display_frame_builder_macros.svh"

module ssdfb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ssdfb_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output ssdfb_pkg::cmd_t pop_data
);

  localparam int DEPTH = ssdfb_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ssdfb_pkg::cmd_t entry [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     level;

  assign full      = level == (AW+1)'(DEPTH);
  assign pop_valid = level != '0;
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      level <= level + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  `SSDFB_ASSERT_IMPLY(a_no_overflow, clk, rst, push && !pop, !full)
  `SSDFB_ASSERT_IMPLY(a_no_underflow, clk, rst, pop, pop_valid)
  `SSDFB_ASSERT_NEXT(a_level_bound, clk, rst, 1'b1, level <= (AW+1)'(DEPTH))

endmodule

>>> hw/rtl/ssdfb_back.sv
`include "seven_segment_display_frame_builder_macros.svh"

module ssdfb_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  ssdfb_pkg::cmd_t q_data,
  output logic            q_pop,
  input  logic            cfg_valid,
  input  logic [2:0]      cfg_data,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic [1:0]      m_tuser,
  output logic            m_tlast
);

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_DATA = 5'b00010,
    PH_ADDR = 5'b00100,
    PH_SEG  = 5'b01000,
    PH_CTRL = 5'b10000
  } phase_t;

  phase_t          phase, phase_next;
  ssdfb_pkg::cmd_t cur;
  logic [1:0]      idx, idx_next;
  logic [2:0]      bright;
  logic            load, take, emit, seg_end;
  logic [7:0]      byte_out;
  logic            opens, closes, lastb;

  assign load    = !m_tvalid || m_tready;
  assign emit    = load && (phase != PH_IDLE);
  // next command is picked up while the control byte goes out
  assign take    = q_valid && ((phase == PH_IDLE) || (phase == PH_CTRL && load));
  assign q_pop   = take;
  assign seg_end = ({1'b0, idx} + 3'd1) == cur.cnt;

  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    byte_out   = ssdfb_pkg::CMD_DATA;
    opens      = 1'b1;
    closes     = 1'b1;
    lastb      = 1'b0;
    unique case (phase)
      PH_IDLE: phase_next = take ? PH_DATA : PH_IDLE;
      PH_DATA: phase_next = PH_ADDR;
      PH_ADDR: begin
        byte_out   = ssdfb_pkg::CMD_ADDR | {6'd0, cur.pos};
        closes     = cur.cnt == 3'd0;
        phase_next = (cur.cnt == 3'd0) ? PH_CTRL : PH_SEG;
        idx_next   = 2'd0;
      end
      PH_SEG: begin
        byte_out   = cur.segs[idx];
        opens      = 1'b0;
        closes     = seg_end;
        phase_next = seg_end ? PH_CTRL : PH_SEG;
        idx_next   = idx + 2'd1;
      end
      PH_CTRL: begin
        byte_out   = ssdfb_pkg::CMD_CTRL | {5'd0, bright};
        lastb      = 1'b1;
        phase_next = take ? PH_DATA : PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      m_tvalid <= 1'b0;
      bright   <= ssdfb_pkg::BRIGHT_RST;
    end else begin
      if (cfg_valid) bright <= cfg_data;
      if (load || phase == PH_IDLE) phase <= phase_next;
      if (load) m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take) cur <= q_data;
    if (load || phase == PH_IDLE) idx <= idx_next;
    if (emit) begin
      m_tdata <= byte_out;
      m_tuser <= {closes, opens};
      m_tlast <= lastb;
    end
  end

  `SSDFB_ASSERT_IMPLY(a_seg_in_range, clk, rst, phase == PH_SEG, {1'b0, idx} < cur.cnt)
  `SSDFB_ASSERT_NEXT(a_ctrl_is_last, clk, rst, emit && phase == PH_CTRL, m_tvalid && m_tlast)
  `SSDFB_ASSERT_NEXT(a_stall_holds_phase, clk, rst,
    m_tvalid && !m_tready && phase != PH_IDLE, $stable(phase))

endmodule

>>> hw/rtl/seven_segment_display_frame_builder.sv
// Builds the bus byte sequence for a four-digit seven-segment driver.
// Input items arrive on s_t*: tuser carries the opcode (raw, integer, time,
// clear), tdata the operand fields. Each command becomes a run of items on
// m_t*: data command 0x40, address 0xC0 plus position, the segment bytes,
// then display control 0x88 | brightness. tuser flags a start condition
// before (bit 0) and a stop condition after (bit 1) each byte; tlast marks
// the control byte that ends the command. Commands out of range are dropped.
// cfg_* writes the 3-bit brightness; cfg_ready is always high.
// On its way to the bus a command passes three decode stages, a two-entry
// command queue and the output register. Throughput: one byte per cycle
// while the receiver is ready; a command takes 3 + segment count bytes
// (7 for integer, time and clear), set by the byte sequencer.
// The decode stages take a new item every cycle while the queue has room.
// Reset empties the pipeline and queue and sets brightness to 7.
// A stalled receiver holds the output register; the queue fills, then
// s_tready drops until bytes drain.
module seven_segment_display_frame_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // number, left_pair, right_pair, raw_seg0..3,
                                 // digit_count, start_position, zero pad
  input  logic [1:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // bus_byte
  output logic [1:0]  m_tuser,   // opens_frame, closes_frame
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);

  logic            push, q_full, q_pop, q_valid;
  ssdfb_pkg::cmd_t push_data, q_data;

  assign cfg_ready = 1'b1;

  ssdfb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_data   (s_tdata),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  ssdfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  ssdfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

>>> test/tb_seven_segment_display_frame_builder.sv
`timescale 1ns / 1ps

module tb_seven_segment_display_frame_builder;

  localparam int HANG_LIMIT  = 3000;
  localparam int SETTLE      = 20;   // covers the trip of a dropped command through the decode stages
  localparam int RAND_ITEMS  = 70;   // per brightness phase
  localparam int N_PHASES    = 5;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       opens;
    logic       closes;
    logic       last;
  } bus_item_t;

  typedef struct {
    ssdfb_pkg::opcode_t op;
    logic signed [14:0] number;
    logic [7:0]         left_pair;
    logic [7:0]         right_pair;
    logic [3:0][7:0]    raw;
    logic [2:0]         digit_count;
    logic [1:0]         start_position;
  } display_cmd_t;

  typedef struct {
    display_cmd_t    cmd;
    int              n_typed;  // -1: bytes come from the predictor
    bus_item_t [0:6] seq;
  } dir_row_t;

  localparam bus_item_t DATA_FRAME = {ssdfb_pkg::CMD_DATA, 3'b110};
  localparam bus_item_t ADDR_ZERO  = {ssdfb_pkg::CMD_ADDR, 3'b100};
  localparam bus_item_t CTRL_FULL  = {ssdfb_pkg::CMD_CTRL | 8'h07, 3'b111};

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // number, left_pair, right_pair, raw_seg0..3,
                          // digit_count, start_position, zero pad
  logic [1:0]  s_tuser;   // opcode
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // bus_byte
  logic [1:0]  m_tuser;   // opens_frame, closes_frame
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_data;

  bus_item_t  pending_bytes[$];
  logic [2:0] bright_level;
  bit         idle_on;
  bit         long_hold_req;
  int         n_errors     = 0;
  int         n_cmds       = 0;
  int         n_dropped    = 0;
  int         n_checked    = 0;
  int         stall_cycles = 0;

  seven_segment_display_frame_builder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] digit_seg(input int d);
    logic [7:0] s;
    case (d)
      0:       s = 8'h3F;
      1:       s = 8'h06;
      2:       s = 8'h5B;
      3:       s = 8'h4F;
      4:       s = 8'h66;
      5:       s = 8'h6D;
      6:       s = 8'h7D;
      7:       s = 8'h07;
      8:       s = 8'h7F;
      default: s = 8'h6F;
    endcase
    return s;
  endfunction

  // queues the bus bytes of one command, returns how many
  function automatic int predict_bus_bytes(input display_cmd_t c);
    logic [7:0] segs [4];
    int         d [4];
    int         n_segs;
    int         v;
    int         mag;
    int         nlz;
    bit         skipping;
    logic [1:0] pos;
    for (int i = 0; i < 4; i++) segs[i] = 8'h00;
    n_segs = ssdfb_pkg::DIGIT_SLOTS;
    pos    = 2'd0;
    case (c.op)
      ssdfb_pkg::OP_RAW: begin
        for (int i = 0; i < 4; i++) segs[i] = c.raw[i];
        n_segs = (c.digit_count > ssdfb_pkg::DIGIT_SLOTS) ?
                 ssdfb_pkg::DIGIT_SLOTS : int'(c.digit_count);
        pos    = c.start_position;
      end
      ssdfb_pkg::OP_INT: begin
        v = c.number;
        if (v > ssdfb_pkg::NUM_MAX || v < ssdfb_pkg::NUM_MIN) return 0;
        mag  = (v < 0) ? -v : v;
        d[0] = mag / 1000;
        d[1] = (mag / 100) % 10;
        d[2] = (mag / 10) % 10;
        d[3] = mag % 10;
        nlz      = 0;
        skipping = 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (skipping && d[i] == 0) begin
            nlz++;
          end else begin
            skipping = 1'b0;
            segs[i]  = digit_seg(d[i]);
          end
        end
        segs[3] = digit_seg(d[3]);
        // minus sits in the blank place nearest the first digit
        if (v < 0 && nlz > 0) segs[nlz - 1] = ssdfb_pkg::SEG_MINUS;
      end
      ssdfb_pkg::OP_TIME: begin
        if (c.left_pair > ssdfb_pkg::PAIR_MAX || c.right_pair > ssdfb_pkg::PAIR_MAX)
          return 0;
        segs[0] = digit_seg(c.left_pair / 10);
        segs[1] = digit_seg(c.left_pair % 10) | ssdfb_pkg::SEG_COLON;
        segs[2] = digit_seg(c.right_pair / 10);
        segs[3] = digit_seg(c.right_pair % 10);
      end
      default: ;  // clear: every segment dark
    endcase
    pending_bytes.push_back(DATA_FRAME);
    pending_bytes.push_back({ssdfb_pkg::CMD_ADDR | {6'b0, pos}, 1'b1, n_segs == 0, 1'b0});
    for (int i = 0; i < n_segs; i++)
      pending_bytes.push_back({segs[i], 1'b0, i + 1 == n_segs, 1'b0});
    pending_bytes.push_back({ssdfb_pkg::CMD_CTRL | {5'b0, bright_level}, 3'b111});
    return n_segs + 3;
  endfunction

  function automatic display_cmd_t cmd_of(input ssdfb_pkg::opcode_t op, input int number,
                                          input int lp, input int rp,
                                          input logic [31:0] raw, input int cnt,
                                          input int pos);
    display_cmd_t c;
    c.op             = op;
    c.number         = number[14:0];
    c.left_pair      = lp[7:0];
    c.right_pair     = rp[7:0];
    c.raw            = raw;
    c.digit_count    = cnt[2:0];
    c.start_position = pos[1:0];
    return c;
  endfunction

  task automatic send_cmd(input display_cmd_t c, input int n_typed,
                          input bus_item_t [0:6] seq);
    int n;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.op;
    s_tdata  <= {4'b0, c.start_position, c.digit_count, c.raw,
                 c.right_pair, c.left_pair, c.number};
    do @(posedge clk); while (!s_tready);
    if (n_typed < 0) begin
      n = predict_bus_bytes(c);
    end else begin
      n = n_typed;
      for (int i = 0; i < n_typed; i++) pending_bytes.push_back(seq[i]);
    end
    n_cmds++;
    if (n == 0) n_dropped++;
  endtask

  task automatic write_brightness(input logic [2:0] level);
    cfg_valid <= 1'b1;
    cfg_data  <= level;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    bright_level = level;
  endtask

  task automatic settle();
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    dir_row_t     dir_tab[$];
    display_cmd_t c;
    int           r;
    rst          <= 1'b1;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tuser      <= ssdfb_pkg::OP_RAW;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    bright_level = ssdfb_pkg::BRIGHT_RST;
    idle_on      = 1'b1;

    // typed rows assume the brightness left by reset
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_CLEAR, 0, 0, 0, 32'h0, 0, 0), 7,
                        {DATA_FRAME, ADDR_ZERO, {8'h00, 3'b000}, {8'h00, 3'b000},
                         {8'h00, 3'b000}, {8'h00, 3'b010}, CTRL_FULL}});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_INT, 9999, 0, 0, 32'h0, 0, 0), 7,
                        {DATA_FRAME, ADDR_ZERO, {8'h6F, 3'b000}, {8'h6F, 3'b000},
                         {8'h6F, 3'b000}, {8'h6F, 3'b010}, CTRL_FULL}});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_INT, -999, 0, 0, 32'h0, 0, 0), 7,
                        {DATA_FRAME, ADDR_ZERO, {ssdfb_pkg::SEG_MINUS, 3'b000},
                         {8'h6F, 3'b000}, {8'h6F, 3'b000}, {8'h6F, 3'b010},
                         CTRL_FULL}});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_INT, 10000, 0, 0, 32'h0, 0, 0), 0, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_INT, -1000, 0, 0, 32'h0, 0, 0), 0, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_INT, 16383, 0, 0, 32'h0, 0, 0), 0, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_INT, -16384, 0, 0, 32'h0, 0, 0), 0, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_TIME, 0, 100, 0, 32'h0, 0, 0), 0, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_TIME, 0, 0, 255, 32'h0, 0, 0), 0, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_INT, 0, 0, 0, 32'h0, 0, 0), -1, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_INT, -1, 0, 0, 32'h0, 0, 0), -1, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_INT, -9, 0, 0, 32'h0, 0, 0), -1, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_INT, -99, 0, 0, 32'h0, 0, 0), -1, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_INT, 1005, 0, 0, 32'h0, 0, 0), -1, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_INT, 7, 0, 0, 32'h0, 0, 0), -1, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_TIME, 0, 0, 0, 32'h0, 0, 0), -1, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_TIME, 0, 99, 99, 32'h0, 0, 0), -1, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_TIME, 0, 12, 34, 32'h0, 0, 0), -1, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_RAW, 0, 0, 0, 32'hFFFF_FFFF, 0, 3), -1, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_RAW, 0, 0, 0, 32'h807F_0180, 4, 0), -1, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_RAW, 0, 0, 0, 32'h5A3C_C3A5, 7, 2), -1, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_RAW, 0, 0, 0, 32'h1234_5678, 1, 1), -1, '0});
    dir_tab.push_back('{cmd_of(ssdfb_pkg::OP_RAW, 0, 0, 0, 32'hDEAD_BEEF, 3, 3), -1, '0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) send_cmd(dir_tab[i].cmd, dir_tab[i].n_typed, dir_tab[i].seq);
    s_tvalid <= 1'b0;
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       write_brightness(3'd0);
        1:       write_brightness(3'd7);
        3:       write_brightness(3'd4);
        default: write_brightness(3'($urandom));
      endcase
      idle_on = (p != N_PHASES - 1);
      if (p == 1) long_hold_req = 1'b1;
      for (int k = 0; k < RAND_ITEMS; k++) begin
        r                = $urandom_range(0, 19);
        c.op             = (r < 5)  ? ssdfb_pkg::OP_RAW :
                           (r < 12) ? ssdfb_pkg::OP_INT :
                           (r < 17) ? ssdfb_pkg::OP_TIME : ssdfb_pkg::OP_CLEAR;
        c.number         = 15'($urandom);
        c.left_pair      = 8'($urandom);
        c.right_pair     = 8'($urandom);
        c.raw            = $urandom;
        c.digit_count    = 3'($urandom);
        c.start_position = 2'($urandom);
        // mostly in range, so most commands reach the byte sequencer
        if (c.op == ssdfb_pkg::OP_INT && $urandom_range(0, 4) != 0)
          c.number = 15'(int'($urandom_range(0, 10998)) - 999);
        if (c.op == ssdfb_pkg::OP_TIME && $urandom_range(0, 6) != 0) begin
          c.left_pair  = 8'($urandom_range(0, 99));
          c.right_pair = 8'($urandom_range(0, 99));
        end
        send_cmd(c, -1, '0);
      end
      s_tvalid <= 1'b0;
      settle();
    end

    $display("%0d commands over %0d brightness settings, %0d rejected as out of range",
             n_cmds, N_PHASES + 1, n_dropped);
    $display("%0d bus bytes checked, with one %0d-cycle receiver hold-off",
             n_checked, HOLD_CYCLES);
    if (n_errors == 0)
      $display("tb_seven_segment_display_frame_builder OK");
    else
      $display("tb_seven_segment_display_frame_builder NOT OK");
    $finish;
  end

  initial begin : sink
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (idle_on && !rst && $urandom_range(0, 11) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : byte_check
    bus_item_t got;
    bus_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata, m_tuser[0], m_tuser[1], m_tlast};
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, got);
        n_errors++;
      end else begin
        want = pending_bytes.pop_front();
        n_checked++;
        if (got.bus_byte !== want.bus_byte) begin
          $display("%0t: bus_byte expected %h actual %h", $time, want.bus_byte, got.bus_byte);
          n_errors++;
        end
        if (got.opens !== want.opens) begin
          $display("%0t: opens_frame expected %b actual %b", $time, want.opens, got.opens);
          n_errors++;
        end
        if (got.closes !== want.closes) begin
          $display("%0t: closes_frame expected %b actual %b", $time, want.closes, got.closes);
          n_errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, got.last);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= HANG_LIMIT) begin
      $display("%0t: nothing moved for %0d cycles, %0d bytes outstanding",
               $time, HANG_LIMIT, pending_bytes.size());
      $display("tb_seven_segment_display_frame_builder NOT OK");
      $finish;
    end
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ssdfb_pkg.sv
hw/rtl/ssdfb_front.sv
hw/rtl/ssdfb_queue.sv
hw/rtl/ssdfb_back.sv
hw/rtl/seven_segment_display_frame_builder.sv
test/tb_seven_segment_display_frame_builder.sv
